// ----- src/bsui_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package bsui_pkg;

  // field widths and default sizing
  localparam int ValueW      = 16;
  localparam int MaxItemsDef = 64;
  localparam int BucketsDef  = 10;

  // controller to datapath commands
  typedef struct packed {
    logic load;       // capture the incoming transaction
    logic drop;       // store full, mark the set as overflowed
    logic sum_step;   // one step of the bucket start sum
    logic walk_rd;    // read store at the walk pointer
    logic walk_adv;   // step the walk pointer
    logic shift_rd;   // read the entry below the shift index
    logic shift_wr;   // write it one place up
    logic place;      // write the new value and bump the counts
    logic emit_rd;    // read the next value for output
    logic clear;      // return the set to empty
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic full;
    logic k_lt_b;
    logic ptr_lt_end;
    logic le;
    logic shift_more;
    logic emit_end;
    logic last;
  } stat_t;

endpackage

`default_nettype wire

// ----- src/bsui_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none

module bsui_ram #(
  parameter int Width = 16,
  parameter int Depth = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output      logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// ----- src/bsui_dp.sv -----
`timescale 1ns / 1ps
`default_nettype none

module bsui_dp #(
  parameter int MaxItems = bsui_pkg::MaxItemsDef,
  parameter int Buckets  = bsui_pkg::BucketsDef
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire bsui_pkg::cmd_t              cmd_i,
  output      bsui_pkg::stat_t             stat_o,
  input  wire logic [bsui_pkg::ValueW-1:0] value_i,
  input  wire logic                        is_last_i,
  output      logic                        valid_o,
  output      logic [bsui_pkg::ValueW-1:0] sorted_value_o,
  output      logic                        last_out_o,
  output      logic                        overflow_o
);

  localparam int VW = bsui_pkg::ValueW;
  localparam int AW = $clog2(MaxItems);
  localparam int CW = $clog2(MaxItems + 1);
  localparam int BW = $clog2(Buckets);
  localparam int MW = $clog2(Buckets + 1);
  localparam int PW = VW + MW;

  logic [VW-1:0] v_q;
  logic          last_q;
  logic [BW-1:0] b_q;
  logic [BW-1:0] k_q;
  logic [CW-1:0] start_q, end_q, ptr_q, idx_q;
  logic [CW-1:0] fill_q [Buckets];
  logic [CW-1:0] count_q;
  logic          dropped_q;
  logic          pend_q, pend_last_q;

  logic [PW-1:0] prod;
  logic [MW-1:0] b_raw;
  logic [BW-1:0] b_new;
  logic [CW-1:0] fill_rd;
  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [VW-1:0] wdata, rdata;

  // bucket index = floor(value * buckets), clamped
  assign prod  = PW'(value_i) * PW'(Buckets);
  assign b_raw = prod[PW-1:VW];
  assign b_new = (b_raw >= MW'(Buckets)) ? BW'(Buckets - 1) : BW'(b_raw);

  assign fill_rd = fill_q[k_q];

  // store port selection
  always_comb begin
    we    = cmd_i.shift_wr | cmd_i.place;
    waddr = cmd_i.shift_wr ? AW'(idx_q) : AW'(ptr_q);
    wdata = cmd_i.shift_wr ? rdata : v_q;
    if (cmd_i.emit_rd) begin
      raddr = AW'(idx_q);
    end else if (cmd_i.shift_rd) begin
      raddr = AW'(idx_q - CW'(1));
    end else if (cmd_i.walk_rd) begin
      raddr = AW'(ptr_q);
    end else begin
      raddr = '0;
    end
  end

  bsui_ram #(
    .Width(VW),
    .Depth(MaxItems)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  // status back to the controller
  assign stat_o.full       = (count_q >= CW'(MaxItems));
  assign stat_o.k_lt_b     = (k_q < b_q);
  assign stat_o.ptr_lt_end = (ptr_q < end_q);
  assign stat_o.le         = (rdata <= v_q);
  assign stat_o.shift_more = (idx_q > ptr_q);
  assign stat_o.emit_end   = (idx_q == count_q - CW'(1));
  assign stat_o.last       = last_q;

  // working registers of the current insertion
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      v_q     <= value_i;
      last_q  <= is_last_i;
      b_q     <= b_new;
      k_q     <= '0;
      start_q <= '0;
    end
    if (cmd_i.sum_step) begin
      if (k_q < b_q) begin
        start_q <= start_q + fill_rd;
        k_q     <= k_q + BW'(1);
      end else begin
        end_q <= start_q + fill_rd;
        ptr_q <= start_q;
      end
    end
    if (cmd_i.walk_adv) begin
      ptr_q <= ptr_q + CW'(1);
    end
  end

  // set state, shift and emit index, result strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      dropped_q   <= 1'b0;
      idx_q       <= '0;
      pend_q      <= 1'b0;
      pend_last_q <= 1'b0;
      for (int i = 0; i < Buckets; i++) begin
        fill_q[i] <= '0;
      end
    end else begin
      pend_q      <= cmd_i.emit_rd;
      pend_last_q <= cmd_i.emit_rd & stat_o.emit_end;
      if (cmd_i.load) begin
        idx_q <= count_q;
      end
      if (cmd_i.drop) begin
        dropped_q <= 1'b1;
        idx_q     <= '0;
      end
      if (cmd_i.shift_wr) begin
        idx_q <= idx_q - CW'(1);
      end
      if (cmd_i.place) begin
        fill_q[b_q] <= fill_q[b_q] + CW'(1);
        count_q     <= count_q + CW'(1);
        idx_q       <= '0;
      end
      if (cmd_i.emit_rd) begin
        idx_q <= idx_q + CW'(1);
      end
      if (cmd_i.clear) begin
        count_q   <= '0;
        dropped_q <= 1'b0;
        idx_q     <= '0;
        for (int i = 0; i < Buckets; i++) begin
          fill_q[i] <= '0;
        end
      end
    end
  end

  assign valid_o        = pend_q;
  assign sorted_value_o = rdata;
  assign last_out_o     = pend_last_q;
  assign overflow_o     = pend_q & dropped_q;

  // checks
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(MaxItems)) else $error("stored count above capacity");

  a_last_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && last_out_o |=> !valid_o) else $error("result after last of set");

  a_clear_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && last_out_o |=> count_q == '0 && !dropped_q)
    else $error("set not emptied after emission");

endmodule

`default_nettype wire

// ----- src/bsui_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none

module bsui_ctrl (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start_i,
  output      logic            busy_o,
  output      bsui_pkg::cmd_t  cmd_o,
  input  wire bsui_pkg::stat_t stat_i
);

  typedef enum logic [8:0] {
    S_IDLE     = 9'b000000001,
    S_SUM      = 9'b000000010,
    S_WALK_RD  = 9'b000000100,
    S_WALK_CMP = 9'b000001000,
    S_SHIFT_RD = 9'b000010000,
    S_SHIFT_WR = 9'b000100000,
    S_PLACE    = 9'b001000000,
    S_EMIT     = 9'b010000000,
    S_DRAIN    = 9'b100000000
  } state_e;

  state_e state_q, state_d;

  // next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_SUM;
        end
      end
      S_SUM: begin
        if (stat_i.full) begin
          cmd_o.drop = 1'b1;
          state_d    = stat_i.last ? S_EMIT : S_IDLE;
        end else begin
          cmd_o.sum_step = 1'b1;
          if (!stat_i.k_lt_b) begin
            state_d = S_WALK_RD;
          end
        end
      end
      S_WALK_RD: begin
        if (stat_i.ptr_lt_end) begin
          cmd_o.walk_rd = 1'b1;
          state_d       = S_WALK_CMP;
        end else begin
          state_d = S_SHIFT_RD;
        end
      end
      S_WALK_CMP: begin
        if (stat_i.le) begin
          cmd_o.walk_adv = 1'b1;
          state_d        = S_WALK_RD;
        end else begin
          state_d = S_SHIFT_RD;
        end
      end
      S_SHIFT_RD: begin
        if (stat_i.shift_more) begin
          cmd_o.shift_rd = 1'b1;
          state_d        = S_SHIFT_WR;
        end else begin
          state_d = S_PLACE;
        end
      end
      S_SHIFT_WR: begin
        cmd_o.shift_wr = 1'b1;
        state_d        = S_SHIFT_RD;
      end
      S_PLACE: begin
        cmd_o.place = 1'b1;
        state_d     = stat_i.last ? S_EMIT : S_IDLE;
      end
      S_EMIT: begin
        cmd_o.emit_rd = 1'b1;
        if (stat_i.emit_end) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        cmd_o.clear = 1'b1;
        state_d     = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);

  // checks
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> busy_o) else $error("accepted transaction not taken up");

endmodule

`default_nettype wire

// ----- src/bucket_sort_unit_interval_top.sv -----
`timescale 1ns / 1ps
`default_nettype none

// bucket sort of Q0.16 fractions, one set at a time
// input: a transaction is taken when start_i is high and busy_o is low;
//   value_i is the fraction, is_last_i closes the set
// each value goes to bucket floor(value * Buckets) and is inserted in
//   order into a single sorted store of MaxItems entries (one RAM)
// busy_o stays high after an insertion is taken while the controller sums
//   the fills of buckets below b (b the bucket index), walks bucket b past
//   entries not above the value, moves the entries from the stop point up
//   one place and writes the value; walk and shift go through the RAM port
// a transaction that finds the store full is dropped without a walk
// on the closing transaction the whole set is read out, one result per
//   cycle on valid_o, each through the registered RAM read, with
//   last_out_o on the final one; busy_o drops in the cycle after that
// items past capacity are dropped and overflow_o is then set on every result of that set
// results cannot be stalled: each is shown for exactly one cycle
// reset empties the set; the store contents are not cleared

module bucket_sort_unit_interval_top #(
  parameter int MaxItems = bsui_pkg::MaxItemsDef,
  parameter int Buckets  = bsui_pkg::BucketsDef
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  output      logic                        busy_o,
  input  wire logic [bsui_pkg::ValueW-1:0] value_i,
  input  wire logic                        is_last_i,
  output      logic                        valid_o,
  output      logic [bsui_pkg::ValueW-1:0] sorted_value_o,
  output      logic                        last_out_o,
  output      logic                        overflow_o
);

  bsui_pkg::cmd_t  cmd;
  bsui_pkg::stat_t stat;

  bsui_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .busy_o (busy_o),
    .cmd_o  (cmd),
    .stat_i (stat)
  );

  bsui_dp #(
    .MaxItems(MaxItems),
    .Buckets (Buckets)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .value_i       (value_i),
    .is_last_i     (is_last_i),
    .valid_o       (valid_o),
    .sorted_value_o(sorted_value_o),
    .last_out_o    (last_out_o),
    .overflow_o    (overflow_o)
  );

endmodule

`default_nettype wire
